// File: src/jpeg_frame_delimiter_defines.svh
// Assertion macros shared by the frame delimiter RTL.
`ifndef JPEG_FRAME_DELIMITER_DEFINES_SVH
`define JPEG_FRAME_DELIMITER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define JFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jpeg_frame_delimiter: assertion failed");

// Check that cons holds in the cycle after ante.
`define JFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jpeg_frame_delimiter: assertion failed");

`else

`define JFD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define JFD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/jfd_pkg.sv
// Constants and types shared by the frame delimiter modules.
package jfd_pkg;

	// Marker bytes of the JPEG stream.
	localparam logic [7:0] BYTE_FF  = 8'hFF;
	localparam logic [7:0] BYTE_SOI = 8'hD8;
	localparam logic [7:0] BYTE_EOI = 8'hD9;

	// Frame size limit in bytes, SOI included.
	localparam int MAX_FRAME_BYTES = 1024 * 1024;
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	// Queue between the classifier and the output stage.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

	// One classified request. A start entry expands to 0xFF then 0xD8.
	typedef struct packed {
		logic [7:0] data;
		logic       soi;
		logic       eoi;
		logic       abort;
	} jfd_entry_t;

	// Head of the queue as seen by the output stage.
	typedef struct packed {
		logic       valid;
		jfd_entry_t entry;
	} jfd_head_t;

endpackage

// File: src/jfd_in_if.sv
// Input byte channel: valid, ready and one raw stream byte.
interface jfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

// File: src/jfd_out_if.sv
// Output byte channel: valid, ready, a frame byte and its marks.
interface jfd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;
	logic       frame_end;
	logic       frame_abort;

	modport source (output valid, output data_byte, output frame_start,
		output frame_end, output frame_abort, input ready);
	modport sink (input valid, input data_byte, input frame_start,
		input frame_end, input frame_abort, output ready);
endinterface

// File: src/jpeg_frame_delimiter.sv
// Top level of the MJPEG SOI/EOI frame delimiter.
//
//   Channel   Direction  Payload
//   stream    in         stream_byte
//   frames    out        data_byte, frame_start, frame_end, frame_abort
//
// One input byte is taken per cycle while the four-entry queue has room.
// A frame byte passes through the queue into the output register; a frame
// start leaves the output register as two bytes (0xFF, then 0xD8).
// Since each start consumes two input bytes, the queue drains at full rate.
// Reset returns to hunting with an empty queue and an empty output register.
// A stall on the output fills the queue, and then the input stalls.
`include "jpeg_frame_delimiter_defines.svh"

module jpeg_frame_delimiter (
	input  logic      clk,
	input  logic      arst_n,
	jfd_in_if.sink    stream,
	jfd_out_if.source frames
);
	import jfd_pkg::*;

	logic       push;
	jfd_entry_t push_entry;
	logic       fifo_full;
	logic       pop;
	jfd_head_t  head;

	// Classifier.
	jfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue between the two sides.
	jfd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (fifo_full),
		.head       (head)
	);

	// Output stage.
	jfd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.frames (frames)
	);

	// The classifier never queues an entry while the queue is full.
	`JFD_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !fifo_full)

	// A frame start byte is 0xFF and carries no other mark.
	`JFD_ASSERT_NOW(a_start_byte, clk, arst_n, frames.valid && frames.frame_start,
		frames.data_byte == BYTE_FF && !frames.frame_end && !frames.frame_abort)

	// While the start byte waits, its entry stays at the head for the 0xD8.
	`JFD_ASSERT_NOW(a_start_held, clk, arst_n, frames.valid && frames.frame_start,
		head.valid && head.entry.soi)

endmodule

// File: src/jfd_front.sv
// Classifier: tracks hunting and frame state and queues the bytes to emit.
module jfd_front (
	input  logic                clk,
	input  logic                arst_n,
	jfd_in_if.sink              stream,
	input  logic                fifo_full,
	output logic                push,
	output jfd_pkg::jfd_entry_t push_entry
);
	import jfd_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HUNT_FF = 2'd1,
		PH_FRAME   = 2'd2
	} phase_t;

	phase_t           phase_q;
	logic [CNT_W-1:0] count_q;
	logic             last_ff_q;

	logic             accept;
	logic [7:0]       b;
	logic [CNT_W-1:0] count_inc;
	logic             ends;
	logic             hits;

	// A request is taken whenever the queue has room.
	assign stream.ready = !fifo_full;
	assign accept       = stream.valid && stream.ready;
	assign b            = stream.stream_byte;
	assign count_inc    = count_q + CNT_W'(1);
	assign ends         = last_ff_q && (b == BYTE_EOI);
	assign hits         = count_inc >= CNT_W'(MAX_FRAME_BYTES);

	// Decide what the accepted byte puts into the queue.
	always_comb begin
		push             = 1'b0;
		push_entry.data  = b;
		push_entry.soi   = 1'b0;
		push_entry.eoi   = 1'b0;
		push_entry.abort = 1'b0;
		unique case (phase_q)
			PH_HUNT_FF: begin
				push           = accept && (b == BYTE_SOI);
				push_entry.soi = 1'b1;
			end
			PH_FRAME: begin
				push             = accept;
				push_entry.eoi   = ends;
				push_entry.abort = !ends && hits;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Phase, byte count and the pending 0xFF flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			count_q   <= '0;
			last_ff_q <= 1'b0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HUNT_FF: begin
					if (b == BYTE_SOI) begin
						phase_q   <= PH_FRAME;
						count_q   <= CNT_W'(2);
						last_ff_q <= 1'b0;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_FRAME: begin
					if (ends || hits) begin
						phase_q   <= PH_HUNT;
						count_q   <= '0;
						last_ff_q <= 1'b0;
					end else begin
						count_q   <= count_inc;
						last_ff_q <= (b == BYTE_FF);
					end
				end
				default: begin
					phase_q <= (b == BYTE_FF) ? PH_HUNT_FF : PH_HUNT;
				end
			endcase
		end
	end
endmodule

// File: src/jfd_fifo.sv
// Short queue of classified entries between the classifier and output stage.
module jfd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jfd_pkg::jfd_entry_t push_entry,
	input  logic                pop,
	output logic                full,
	output jfd_pkg::jfd_head_t  head
);
	import jfd_pkg::*;

	jfd_entry_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign full       = fill_q == FILL_W'(FIFO_DEPTH);
	assign head.valid = fill_q != '0;
	assign head.entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end
endmodule

// File: src/jfd_back.sv
// Output stage: expands queued entries into output bytes in a register.
module jfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  jfd_pkg::jfd_head_t head,
	output logic               pop,
	jfd_out_if.source          frames
);
	import jfd_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;
	logic       start_q;
	logic       end_q;
	logic       abort_q;
	logic       half_q;
	logic       load;
	logic       first_half;

	assign frames.valid       = valid_q;
	assign frames.data_byte   = data_q;
	assign frames.frame_start = start_q;
	assign frames.frame_end   = end_q;
	assign frames.frame_abort = abort_q;

	// The register takes a new byte when empty or when its byte is taken.
	assign load       = !valid_q || frames.ready;
	assign first_half = head.entry.soi && !half_q;
	assign pop        = load && head.valid && !first_half;

	// Control of the output register and the start expansion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (load) begin
			valid_q <= head.valid;
			if (head.valid) begin
				half_q <= first_half;
			end
		end
	end

	// Output payload; a start entry gives 0xFF marked first, then its 0xD8.
	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			data_q  <= first_half ? BYTE_FF : head.entry.data;
			start_q <= first_half;
			end_q   <= head.entry.eoi;
			abort_q <= head.entry.abort;
		end
	end
endmodule
